// ===== sv/owb_pkg.sv =====
// Package: function, CSR, status and phase codes, timing constants and the response record of the 1-Wire master.
`default_nettype none
package owb_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);

   localparam logic [9:0] WR1_LOW_US     = 10'd6;
   localparam logic [9:0] WR0_LOW_US     = 10'd60;
   localparam logic [9:0] WR_SLOT_US     = 10'd70;
   localparam logic [9:0] RD_LOW_US      = 10'd3;
   localparam logic [9:0] RD_SAMPLE_TICK = 10'd14;
   localparam logic [9:0] RD_SLOT_US     = 10'd68;
   localparam logic [9:0] RECOVER_US     = 10'd5;

   localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
   localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd70;
   localparam logic [9:0] PRESENCE_TO_DEF   = 10'd300;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_RESET = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_RESET_LOW     = 2'd0,
      CSR_PRESENCE_WAIT = 2'd1,
      CSR_PRESENCE_TO   = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_PRESENCE = 2'd1,
      ST_PRESENCE_LONG = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RST_LOW   = 4'd1,
      PH_RST_WAIT  = 4'd2,
      PH_POLL_FALL = 4'd3,
      PH_POLL_RISE = 4'd4,
      PH_RECOVER   = 4'd5,
      PH_WRITE     = 4'd6,
      PH_READ      = 4'd7
   } phase_type;

   typedef struct packed {
      logic       bus_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_data;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/one_wire_bus_master_top.sv =====
// 1-Wire bus master timing engine: state update per request and a two-entry response queue.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  func, write_data, line_level
//  rsp      out        rsp_valid/rsp_ready  bus_drive_low, busy_res, done_res, status, read_data
//  csr      in         csr_we               csr_index, csr_wdata
//
// One request per clock while req_ready is high; its response is registered into the response queue.
// Two response entries: requests keep flowing while one response waits.
// req_ready drops only when both response entries are full.
// Synchronous active-high reset restores the default timing registers and idles the bus.
`default_nettype none
module one_wire_bus_master_top
   import owb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_write_data,
   input  wire logic       req_line_level,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic       rsp_bus_drive_low,
   output      logic       rsp_busy_res,
   output      logic       rsp_done_res,
   output      logic [1:0] rsp_status,
   output      logic [7:0] rsp_read_data,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [9:0] csr_wdata
);

   logic [9:0] reset_low_ff;
   logic [7:0] presence_wait_ff;
   logic [9:0] presence_to_ff;

   phase_type            phase_ff, phase_in;
   logic [9:0]           us_cnt_ff, us_cnt_in;
   logic [BIT_CNT_W-1:0] bit_idx_ff, bit_idx_in;
   logic [7:0]           tx_shift_ff, tx_shift_in;
   logic [7:0]           rx_accum_ff, rx_accum_in;
   logic [1:0]           op_kind_ff, op_kind_in;
   logic                 drive_low_ff, drive_low_in;
   logic [7:0]           last_read_ff, last_read_in;

   rsp_type    head_ff, head_in, tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   rsp_type    new_rsp;

   logic                 push, pop;
   logic [9:0]           cnt_inc, reset_low_min, presence_to_min, low_time;
   logic [BIT_CNT_W-1:0] bit_next;
   logic                 done;
   logic [1:0]           status;

   assign req_ready = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   assign cnt_inc         = us_cnt_ff + 10'd1;
   assign reset_low_min   = (reset_low_ff == 10'd0) ? 10'd1 : reset_low_ff;
   assign presence_to_min = (presence_to_ff == 10'd0) ? 10'd1 : presence_to_ff;
   assign low_time        = tx_shift_ff[0] ? WR1_LOW_US : WR0_LOW_US;
   assign bit_next        = bit_idx_ff + BIT_CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= RESET_LOW_DEF;
         presence_wait_ff <= PRESENCE_WAIT_DEF;
         presence_to_ff   <= PRESENCE_TO_DEF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RESET_LOW:     reset_low_ff     <= csr_wdata;
            CSR_PRESENCE_WAIT: presence_wait_ff <= csr_wdata[7:0];
            CSR_PRESENCE_TO:   presence_to_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      us_cnt_in    = us_cnt_ff;
      bit_idx_in   = bit_idx_ff;
      tx_shift_in  = tx_shift_ff;
      rx_accum_in  = rx_accum_ff;
      op_kind_in   = op_kind_ff;
      drive_low_in = drive_low_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;
      status       = ST_OK;
      if (req_func != FUNC_TICK) begin
         if (phase_ff == PH_IDLE) begin
            op_kind_in   = req_func;
            us_cnt_in    = 10'd0;
            bit_idx_in   = '0;
            drive_low_in = 1'b1;
            unique case (req_func)
               FUNC_RESET: phase_in = PH_RST_LOW;
               FUNC_WRITE: begin
                  tx_shift_in = req_write_data;
                  phase_in    = PH_WRITE;
               end
               default: begin
                  rx_accum_in = 8'd0;
                  phase_in    = PH_READ;
               end
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         us_cnt_in = cnt_inc;
         unique case (phase_ff)
            PH_RST_LOW: begin
               if (cnt_inc >= reset_low_min) begin
                  drive_low_in = 1'b0;
                  us_cnt_in    = 10'd0;
                  phase_in     = (presence_wait_ff == 8'd0) ? PH_POLL_FALL : PH_RST_WAIT;
               end
            end
            PH_RST_WAIT: begin
               if (cnt_inc >= {2'b00, presence_wait_ff}) begin
                  us_cnt_in = 10'd0;
                  phase_in  = PH_POLL_FALL;
               end
            end
            PH_POLL_FALL: begin
               if (!req_line_level) begin
                  us_cnt_in = 10'd0;
                  phase_in  = PH_POLL_RISE;
               end else if (cnt_inc >= presence_to_min) begin
                  done   = 1'b1;
                  status = ST_NO_PRESENCE;
               end
            end
            PH_POLL_RISE: begin
               if (req_line_level) begin
                  us_cnt_in = 10'd0;
                  phase_in  = PH_RECOVER;
               end else if (cnt_inc >= presence_to_min) begin
                  done   = 1'b1;
                  status = ST_PRESENCE_LONG;
               end
            end
            PH_RECOVER: begin
               if (cnt_inc >= RECOVER_US) done = 1'b1;
            end
            PH_WRITE: begin
               if (cnt_inc >= low_time) drive_low_in = 1'b0;
               if (cnt_inc >= WR_SLOT_US) begin
                  tx_shift_in = {1'b0, tx_shift_ff[7:1]};
                  bit_idx_in  = bit_next;
                  if (32'(bit_next) >= BITS_PER_BYTE) begin
                     done = 1'b1;
                  end else begin
                     us_cnt_in    = 10'd0;
                     drive_low_in = 1'b1;
                  end
               end
            end
            PH_READ: begin
               if (cnt_inc >= RD_LOW_US) drive_low_in = 1'b0;
               if (cnt_inc == RD_SAMPLE_TICK && req_line_level && 32'(bit_idx_ff) < 8)
                  rx_accum_in[bit_idx_ff[2:0]] = 1'b1;
               if (cnt_inc >= RD_SLOT_US) begin
                  bit_idx_in = bit_next;
                  if (32'(bit_next) >= BITS_PER_BYTE) begin
                     last_read_in = rx_accum_in;
                     done         = 1'b1;
                  end else begin
                     us_cnt_in    = 10'd0;
                     drive_low_in = 1'b1;
                  end
               end
            end
            default: done = 1'b1;
         endcase
         if (done) begin
            phase_in     = PH_IDLE;
            us_cnt_in    = 10'd0;
            drive_low_in = 1'b0;
         end
      end
      new_rsp.bus_drive_low = drive_low_in;
      new_rsp.busy_res      = (phase_in != PH_IDLE);
      new_rsp.done_res      = done;
      new_rsp.status        = status;
      new_rsp.read_data     = last_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         us_cnt_ff    <= 10'd0;
         bit_idx_ff   <= '0;
         tx_shift_ff  <= 8'd0;
         rx_accum_ff  <= 8'd0;
         op_kind_ff   <= 2'd0;
         drive_low_ff <= 1'b0;
         last_read_ff <= 8'd0;
      end else if (push) begin
         phase_ff     <= phase_in;
         us_cnt_ff    <= us_cnt_in;
         bit_idx_ff   <= bit_idx_in;
         tx_shift_ff  <= tx_shift_in;
         rx_accum_ff  <= rx_accum_in;
         op_kind_ff   <= op_kind_in;
         drive_low_ff <= drive_low_in;
         last_read_ff <= last_read_in;
      end
   end

   // response queue: head is shown, tail holds the second entry
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
      if (pop) begin
         head_in = (count_ff == 2'd2) ? tail_ff : new_rsp;
      end else if (count_ff == 2'd0) begin
         head_in = new_rsp;
      end
      if (push && ((count_ff == 2'd1 && !pop) || (count_ff == 2'd2 && pop))) tail_in = new_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_bus_drive_low = head_ff.bus_drive_low;
   assign rsp_busy_res      = head_ff.busy_res;
   assign rsp_done_res      = head_ff.done_res;
   assign rsp_status        = head_ff.status;
   assign rsp_read_data     = head_ff.read_data;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("response queue overflow");
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !drive_low_ff) else $error("bus held low while idle");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res) else $error("done while busy");
   a_status_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_done_res) else $error("status without done");
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 && !rsp_ready |=> count_ff == 2'd2) else $error("entry lost");

endmodule
`default_nettype wire

// ===== dv/tb_one_wire_bus_master_top.sv =====
// Testbench for the 1-Wire bus master: random-paced request/response traffic against a predictor.
module tb_one_wire_bus_master_top;
   timeunit 1ns;
   timeprecision 1ps;
   import owb_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      func_type   func;
      logic [7:0] wdata;
      logic       level;
   } bus_req_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = FUNC_TICK;
   logic [7:0] req_write_data = 8'h00;
   logic       req_line_level = 1'b1;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_bus_drive_low;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [1:0] rsp_status;
   logic [7:0] rsp_read_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = CSR_RESET_LOW;
   logic [9:0] csr_wdata = 10'd0;

   one_wire_bus_master_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_write_data    (req_write_data),
      .req_line_level    (req_line_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bus_drive_low (rsp_bus_drive_low),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_status        (rsp_status),
      .rsp_read_data     (rsp_read_data),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // bus timing predictor state
   logic [9:0] cfg_reset_low     = RESET_LOW_DEF;
   logic [7:0] cfg_presence_wait = PRESENCE_WAIT_DEF;
   logic [9:0] cfg_presence_to   = PRESENCE_TO_DEF;
   phase_type  bus_phase = PH_IDLE;
   logic [9:0] us_cnt    = '0;
   int         bit_cnt   = 0;
   logic [7:0] tx_byte   = '0;
   logic [7:0] rx_byte   = '0;
   logic       drive_low = 1'b0;
   logic [7:0] last_rd   = '0;

   bus_req_type pend_q[$];
   rsp_type     exp_rsp_q[$];
   bus_req_type cur_req;
   int          pushed_cnt = 0;
   int          rsp_cnt = 0;
   int          hold_left = 0;
   int          err_cnt = 0;
   int          cyc_cnt = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cyc_cnt++;
      if (cyc_cnt > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic predict_bus_step(input bus_req_type r);
      logic [9:0] low_eff;
      logic [9:0] to_eff;
      logic [9:0] low_time;
      logic       done;
      status_type st;
      rsp_type    e;
      low_eff = (cfg_reset_low == 10'd0) ? 10'd1 : cfg_reset_low;
      to_eff  = (cfg_presence_to == 10'd0) ? 10'd1 : cfg_presence_to;
      done    = 1'b0;
      st      = ST_OK;
      if (r.func != FUNC_TICK) begin
         // a start while busy is dropped and takes no time
         if (bus_phase == PH_IDLE) begin
            us_cnt    = '0;
            bit_cnt   = 0;
            drive_low = 1'b1;
            case (r.func)
               FUNC_RESET: bus_phase = PH_RST_LOW;
               FUNC_WRITE: begin
                  tx_byte   = r.wdata;
                  bus_phase = PH_WRITE;
               end
               default: begin
                  rx_byte   = '0;
                  bus_phase = PH_READ;
               end
            endcase
         end
      end else if (bus_phase != PH_IDLE) begin
         us_cnt = us_cnt + 10'd1;
         case (bus_phase)
            PH_RST_LOW: begin
               if (us_cnt >= low_eff) begin
                  drive_low = 1'b0;
                  us_cnt    = '0;
                  if (cfg_presence_wait == 8'd0) bus_phase = PH_POLL_FALL;
                  else bus_phase = PH_RST_WAIT;
               end
            end
            PH_RST_WAIT: begin
               if (us_cnt >= {2'b00, cfg_presence_wait}) begin
                  us_cnt    = '0;
                  bus_phase = PH_POLL_FALL;
               end
            end
            PH_POLL_FALL: begin
               if (!r.level) begin
                  us_cnt    = '0;
                  bus_phase = PH_POLL_RISE;
               end else if (us_cnt >= to_eff) begin
                  done = 1'b1;
                  st   = ST_NO_PRESENCE;
               end
            end
            PH_POLL_RISE: begin
               if (r.level) begin
                  us_cnt    = '0;
                  bus_phase = PH_RECOVER;
               end else if (us_cnt >= to_eff) begin
                  done = 1'b1;
                  st   = ST_PRESENCE_LONG;
               end
            end
            PH_RECOVER: begin
               if (us_cnt >= RECOVER_US) done = 1'b1;
            end
            PH_WRITE: begin
               low_time = tx_byte[0] ? WR1_LOW_US : WR0_LOW_US;
               if (us_cnt >= low_time) drive_low = 1'b0;
               if (us_cnt >= WR_SLOT_US) begin
                  tx_byte = tx_byte >> 1;
                  bit_cnt++;
                  if (bit_cnt >= BITS_PER_BYTE) begin
                     done = 1'b1;
                  end else begin
                     us_cnt    = '0;
                     drive_low = 1'b1;
                  end
               end
            end
            PH_READ: begin
               if (us_cnt >= RD_LOW_US) drive_low = 1'b0;
               if (us_cnt == RD_SAMPLE_TICK && r.level && bit_cnt < 8) rx_byte[bit_cnt] = 1'b1;
               if (us_cnt >= RD_SLOT_US) begin
                  bit_cnt++;
                  if (bit_cnt >= BITS_PER_BYTE) begin
                     last_rd = rx_byte;
                     done    = 1'b1;
                  end else begin
                     us_cnt    = '0;
                     drive_low = 1'b1;
                  end
               end
            end
            default: done = 1'b1;
         endcase
         if (done) begin
            bus_phase = PH_IDLE;
            us_cnt    = '0;
            drive_low = 1'b0;
         end
      end
      e.bus_drive_low = drive_low;
      e.busy_res      = (bus_phase != PH_IDLE);
      e.done_res      = done;
      e.status        = st;
      e.read_data     = last_rd;
      exp_rsp_q.push_back(e);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_bus_step(cur_req);
         if (!req_valid || req_ready) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = pend_q.pop_front();
               req_valid      <= 1'b1;
               req_func       <= cur_req.func;
               req_write_data <= cur_req.wdata;
               req_line_level <= cur_req.level;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         err_cnt++;
      end
   endfunction

   // response monitor
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (exp_rsp_q.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               err_cnt++;
            end else begin
               e = exp_rsp_q.pop_front();
               check_field("bus_drive_low", 8'(e.bus_drive_low), 8'(rsp_bus_drive_low));
               check_field("busy_res", 8'(e.busy_res), 8'(rsp_busy_res));
               check_field("done_res", 8'(e.done_res), 8'(rsp_done_res));
               check_field("status", 8'(e.status), 8'(rsp_status));
               check_field("read_data", e.read_data, rsp_read_data);
            end
            rsp_cnt++;
            // long stall to back up the response queue
            if (rsp_cnt == 300) hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic push_req(func_type f, logic [7:0] wdata, logic level);
      bus_req_type r;
      r.func  = f;
      r.wdata = wdata;
      r.level = level;
      pend_q.push_back(r);
      pushed_cnt++;
   endtask

   task automatic push_stray();
      push_req(func_type'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
   endtask

   task automatic gen_reset_op(int fall_delay, int low_len, bit strays);
      int pre;
      pre = ((cfg_reset_low == 10'd0) ? 1 : int'(cfg_reset_low)) + int'(cfg_presence_wait);
      push_req(FUNC_RESET, 8'($urandom), 1'($urandom));
      for (int i = 0; i < pre; i++) begin
         push_req(FUNC_TICK, 8'($urandom), 1'($urandom));
         if (strays && $urandom_range(19) == 0) push_stray();
      end
      repeat (fall_delay) push_req(FUNC_TICK, 8'($urandom), 1'b1);
      repeat (low_len) push_req(FUNC_TICK, 8'($urandom), 1'b0);
      repeat (6 + $urandom_range(0, 2)) push_req(FUNC_TICK, 8'($urandom), 1'b1);
   endtask

   task automatic gen_write_op(logic [7:0] data, bit strays);
      push_req(FUNC_WRITE, data, 1'($urandom));
      for (int i = 0; i < BITS_PER_BYTE * WR_SLOT_US; i++) begin
         push_req(FUNC_TICK, 8'($urandom), 1'($urandom));
         if (strays && i < 500 && $urandom_range(49) == 0) push_stray();
      end
      repeat ($urandom_range(0, 2)) push_req(FUNC_TICK, 8'($urandom), 1'($urandom));
   endtask

   task automatic gen_read_op(bit all_high, bit strays);
      push_req(FUNC_READ, 8'($urandom), 1'($urandom));
      for (int i = 0; i < BITS_PER_BYTE * RD_SLOT_US; i++) begin
         push_req(FUNC_TICK, 8'($urandom), all_high ? 1'b1 : 1'($urandom));
         if (strays && i < 500 && $urandom_range(49) == 0) push_stray();
      end
      repeat ($urandom_range(0, 2)) push_req(FUNC_TICK, 8'($urandom), 1'($urandom));
   endtask

   // idle ticks and reset starts only, so no long byte operation begins here
   task automatic gen_noise(int n);
      repeat (n) begin
         if ($urandom_range(9) < 7) push_req(FUNC_TICK, 8'($urandom), 1'($urandom));
         else push_req(FUNC_RESET, 8'($urandom), 1'($urandom));
      end
   endtask

   function automatic int pick_near(int lim);
      if ($urandom_range(3) != 0) return $urandom_range(0, lim - 1);
      return $urandom_range(lim - 1, lim + 1);
   endfunction

   task automatic gen_random_chunk(int target);
      int to_eff;
      int start;
      int pick;
      to_eff = (cfg_presence_to == 10'd0) ? 1 : int'(cfg_presence_to);
      start  = pushed_cnt;
      while (pushed_cnt - start < target) begin
         pick = $urandom_range(99);
         if (pick < 75) gen_reset_op(pick_near(to_eff), 1 + pick_near(to_eff), 1'b1);
         else gen_noise($urandom_range(1, 12));
      end
   endtask

   task automatic write_csr(csr_idx_type idx, logic [9:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RESET_LOW:     cfg_reset_low = val;
         CSR_PRESENCE_WAIT: cfg_presence_wait = val[7:0];
         default:           cfg_presence_to = val;
      endcase
   endtask

   task automatic set_timing(logic [9:0] low, logic [7:0] pwait, logic [9:0] to);
      write_csr(CSR_RESET_LOW, low);
      write_csr(CSR_PRESENCE_WAIT, {2'b00, pwait});
      write_csr(CSR_PRESENCE_TO, to);
   endtask

   // drain all requests and responses, then tick until the bus engine is idle
   task automatic settle();
      do begin
         do @(negedge clock);
         while (pend_q.size() != 0 || exp_rsp_q.size() != 0 || req_valid);
         if (bus_phase != PH_IDLE) begin
            repeat (32) push_req(FUNC_TICK, 8'($urandom), 1'($urandom));
         end
      end while (bus_phase != PH_IDLE);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 70;

      // idle ticks and a full write at power-on timing
      push_req(FUNC_TICK, 8'hFF, 1'b1);
      push_req(FUNC_TICK, 8'h00, 1'b0);
      gen_write_op(8'($urandom), 1'b1);
      settle();

      // zero registers act as minimum; presence ok, missing, too long
      set_timing(10'd0, 8'd0, 10'd0);
      gen_reset_op(0, 1, 1'b0);
      gen_reset_op(1, 1, 1'b0);
      gen_reset_op(0, 3, 1'b0);
      settle();

      send_idle_pct = 70;
      recv_idle_pct = 11;
      set_timing(10'($urandom_range(0, 5)), 8'($urandom_range(0, 3)),
                 10'($urandom_range(0, 6)));
      gen_read_op(1'b0, 1'b1);
      gen_random_chunk(100);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_timing(10'($urandom_range(1, 30)), 8'($urandom_range(0, 20)),
                 10'($urandom_range(1, 25)));
      gen_random_chunk(120);
      settle();

      repeat (10) @(posedge clock);
      if (err_cnt == 0 && exp_rsp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
